>>> sv/kdeg_pkg.sv
// kdeg_pkg: shared types and constants for the key debounce event generator
// used by kdeg_step and key_debounce_event_gen_top; no dependencies
package kdeg_pkg;

    localparam int unsigned MsW      = 8;
    localparam int unsigned HeldW    = 16;
    localparam int unsigned KeysW    = 3;

    // latch bit positions: door bit 2, stop bit 1, on/off bit 0 (1 = active)
    localparam int unsigned DoorIdx  = 2;
    localparam int unsigned StopIdx  = 1;
    localparam int unsigned OnoffIdx = 0;

    localparam logic [2:0] LatchRst      = 3'b101;
    localparam logic [1:0] KeysOnoff     = 2'b01;
    localparam logic [1:0] KeysStop      = 2'b10;
    localparam logic [1:0] KeysNone      = 2'b00;
    localparam logic [1:0] PrevKeysRst   = KeysOnoff;
    localparam logic       PrevDoorRst   = 1'b1;
    localparam logic [MsW-1:0] DebounceRst = 8'd40;
    localparam logic [HeldW-1:0] HeldMax = {HeldW{1'b1}};

    localparam logic KeyIdStop  = 1'b0;
    localparam logic KeyIdOnoff = 1'b1;
    localparam logic StatusSet     = 1'b0;
    localparam logic StatusRelease = 1'b1;

    // one tick transaction
    typedef struct packed {
        logic           door_pin;
        logic           stop_pin;
        logic           onoff_pin;
        logic [MsW-1:0] elapsed_ms;
        logic           powered;
    } kdeg_tick_t;

    // one result transaction
    typedef struct packed {
        logic             evaluated;
        logic             door_event;
        logic             door_status;
        logic             key_event;
        logic             key_id;
        logic             key_status;
        logic [HeldW-1:0] held_ms;
    } kdeg_result_t;

endpackage

>>> sv/kdeg_step.sv
// kdeg_step: debounce state registers and the single-pass tick evaluation
// depends on kdeg_pkg
module kdeg_step
    import kdeg_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  kdeg_tick_t     tick,
    input  logic [MsW-1:0] debounce_ms,
    output kdeg_result_t   result
);

    logic [MsW-1:0]   bounce_timer_reg, bounce_timer_next;
    logic [KeysW-1:0] latched_keys_reg, latched_keys_next;
    logic [1:0]       previous_keys_reg, previous_keys_next;
    logic             previous_door_reg, previous_door_next;
    logic [HeldW-1:0] press_timer_reg, press_timer_next;

    logic [KeysW-1:0] sample;
    logic [HeldW:0]   press_sum;
    logic [HeldW-1:0] press_sat;
    logic [MsW-1:0]   bt_mid;
    logic [1:0]       keys;
    logic             door;
    logic             ev;
    logic             ev_id;
    logic             ev_st;

    always_comb
    begin
        sample = {~tick.door_pin, ~tick.stop_pin, ~tick.onoff_pin};
        press_sum = {1'b0, press_timer_reg} + {{(HeldW + 1 - MsW){1'b0}}, tick.elapsed_ms};
        press_sat = press_sum[HeldW] ? HeldMax : press_sum[HeldW-1:0];

        latched_keys_next  = latched_keys_reg;
        press_timer_next   = press_sat;
        bt_mid             = bounce_timer_reg;
        previous_keys_next = previous_keys_reg;
        previous_door_next = previous_door_reg;
        result             = '0;
        ev    = 1'b0;
        ev_id = KeyIdStop;
        ev_st = StatusSet;

        // timer running: relatch on change, else count down saturating
        if (bounce_timer_reg != '0)
        begin
            if (latched_keys_reg != sample)
            begin
                latched_keys_next = sample;
                bt_mid = debounce_ms;
                if (sample != '0)
                begin
                    press_timer_next = '0;
                end
            end
            else
            begin
                bt_mid = (bounce_timer_reg > tick.elapsed_ms)
                       ? bounce_timer_reg - tick.elapsed_ms : '0;
            end
        end

        bounce_timer_next = bt_mid;
        door = latched_keys_next[DoorIdx];
        keys = latched_keys_next[StopIdx:OnoffIdx];

        if (bt_mid == '0)
        begin
            result.evaluated = 1'b1;
            result.held_ms   = press_timer_next;
            bounce_timer_next = debounce_ms;
            if (door != previous_door_reg)
            begin
                result.door_event  = 1'b1;
                result.door_status = door;
                previous_door_next = door;
            end
            if (keys == KeysNone)
            begin
                if (previous_keys_reg == KeysOnoff)
                begin
                    ev    = 1'b1;
                    ev_id = KeyIdOnoff;
                    ev_st = StatusRelease;
                end
            end
            else if (previous_keys_reg == KeysNone)
            begin
                if (keys == KeysStop)
                begin
                    ev    = 1'b1;
                    ev_id = KeyIdStop;
                end
                else if (keys == KeysOnoff)
                begin
                    ev    = 1'b1;
                    ev_id = KeyIdOnoff;
                end
            end
            previous_keys_next = keys;
            // power gating drops stop key events
            if (ev && (!tick.powered || ev_id == KeyIdOnoff))
            begin
                result.key_event  = 1'b1;
                result.key_id     = ev_id;
                result.key_status = ev_st;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_timer_reg  <= '0;
            latched_keys_reg  <= LatchRst;
            previous_keys_reg <= PrevKeysRst;
            previous_door_reg <= PrevDoorRst;
            press_timer_reg   <= '0;
        end
        else if (step_en)
        begin
            bounce_timer_reg  <= bounce_timer_next;
            latched_keys_reg  <= latched_keys_next;
            previous_keys_reg <= previous_keys_next;
            previous_door_reg <= previous_door_next;
            press_timer_reg   <= press_timer_next;
        end
    end

endmodule

>>> sv/key_debounce_event_gen_top.sv
// key_debounce_event_gen_top: tick input register, debounce step, result register
// depends on kdeg_pkg and kdeg_step
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  tick in  | in_valid / in_stall       | door_pin stop_pin onoff_pin elapsed_ms powered
//  result   | out_valid / out_stall     | evaluated door_event door_status key_event
//           |                           | key_id key_status held_ms
//  config   | cfg_valid / cfg_ready     | debounce_ms (write only)
//
// a tick is in the input register after its accepting edge and then moves on into the
// result register, from which its result transaction is offered; one transaction per
// cycle sustained while out_stall is low; the input register feeds the step logic, which
// updates state and loads the result register in the same edge
// reset clears the pipeline valids and loads the debounce state and a 40 ms window
// in_stall rises only when the input register holds a tick and the result register is
// full and stalled; cfg_ready is always high
module key_debounce_event_gen_top
    import kdeg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // tick channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             door_pin,
    input  logic             stop_pin,
    input  logic             onoff_pin,
    input  logic [MsW-1:0]   elapsed_ms,
    input  logic             powered,
    // config channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [MsW-1:0]   debounce_ms,
    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic             evaluated,
    output logic             door_event,
    output logic             door_status,
    output logic             key_event,
    output logic             key_id,
    output logic             key_status,
    output logic [HeldW-1:0] held_ms
);

    logic           in_valid_reg;
    kdeg_tick_t     tick_reg;
    logic           out_valid_reg;
    kdeg_result_t   result_reg;
    kdeg_result_t   result_next;
    logic [MsW-1:0] debounce_ms_reg;

    logic out_free;
    logic step_en;
    logic in_take;

    // result register can take a new transaction when empty or draining
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_en   = in_valid_reg && out_free;
    // input register can take a tick when empty or moving on this edge
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= DebounceRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            debounce_ms_reg <= debounce_ms;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg <= '{door_pin:   door_pin,
                          stop_pin:   stop_pin,
                          onoff_pin:  onoff_pin,
                          elapsed_ms: elapsed_ms,
                          powered:    powered};
        end
    end

    kdeg_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .tick        (tick_reg),
        .debounce_ms (debounce_ms_reg),
        .result      (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign evaluated   = result_reg.evaluated;
    assign door_event  = result_reg.door_event;
    assign door_status = result_reg.door_status;
    assign key_event   = result_reg.key_event;
    assign key_id      = result_reg.key_id;
    assign key_status  = result_reg.key_status;
    assign held_ms     = result_reg.held_ms;

    // held time and key events only come out of an evaluation
    a_held_needs_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evaluated) |-> (held_ms == '0 && !key_event && !door_event))
        else $error("result fields set without evaluation");

    // door status is only reported together with a door event
    a_door_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !door_event) |-> !door_status)
        else $error("door status without door event");

    // a tick in the input register moves on whenever the result side is free
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> (out_valid_reg))
        else $error("tick lost between input and result registers");

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_reg)))
        else $error("stalled result changed");

endmodule

>>> bench/key_debounce_event_gen_top_test.sv
// key_debounce_event_gen_top_test: self-checking bench for the key debounce event generator,
// a directed table of ticks and then random key sequences, checked against a local predictor
// depends on kdeg_pkg and key_debounce_event_gen_top
module key_debounce_event_gen_top_test;
    import kdeg_pkg::*;

    // one row of the directed table; want is only used where typed is set
    typedef struct packed {
        kdeg_tick_t   tick;
        logic         typed;
        kdeg_result_t want;
    } dir_row_t;

    // cycles without any transaction before the run is declared hung
    localparam int unsigned WatchLimit = 2000;
    // ticks per random phase, one debounce window per phase
    localparam int unsigned PhaseTicks = 230;
    localparam int unsigned NumPhases  = 7;
    // ticks in the long hold that drives the press timer into saturation
    localparam int unsigned HoldTicks  = 270;

    // directed table, window at its reset value of 40 ms
    localparam dir_row_t DirRows [25] = '{
        // first tick after reset: timer is zero, latch evaluated at once, nothing changed
        '{'{1'b0, 1'b1, 1'b0, 8'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
        // same pins, largest step: countdown saturates at zero, press time is the step
        '{'{1'b0, 1'b1, 1'b0, 8'd255, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd255}},
        // on/off released, then settled: release event
        '{'{1'b0, 1'b1, 1'b1, 8'd10,  1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1, 8'd255, 1'b0}, 1'b0, '0},
        // stop pressed while powered: event dropped
        '{'{1'b0, 1'b0, 1'b1, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, 8'd255, 1'b1}, 1'b0, '0},
        // stop released: no event
        '{'{1'b0, 1'b1, 1'b1, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1, 8'd255, 1'b0}, 1'b0, '0},
        // stop pressed while unpowered: set event
        '{'{1'b0, 1'b0, 1'b1, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, 8'd255, 1'b0}, 1'b0, '0},
        // on/off joins stop: both held, no event
        '{'{1'b0, 1'b0, 1'b0, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0, 8'd255, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1, 8'd255, 1'b0}, 1'b0, '0},
        // both pressed together from idle: no event
        '{'{1'b0, 1'b0, 1'b0, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0, 8'd255, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1, 8'd255, 1'b0}, 1'b0, '0},
        // on/off pressed while powered: passes
        '{'{1'b0, 1'b1, 1'b0, 8'd5,   1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, 8'd255, 1'b1}, 1'b0, '0},
        // door opens and closes: door events, never gated by power
        '{'{1'b1, 1'b1, 1'b0, 8'd5,   1'b1}, 1'b0, '0},
        '{'{1'b1, 1'b1, 1'b0, 8'd255, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, 8'd5,   1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, 8'd255, 1'b0}, 1'b0, '0},
        // partial countdown, no evaluation
        '{'{1'b0, 1'b1, 1'b0, 8'd20,  1'b0}, 1'b0, '0}
    };

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             door_pin;
    logic             stop_pin;
    logic             onoff_pin;
    logic [MsW-1:0]   elapsed_ms;
    logic             powered;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [MsW-1:0]   debounce_ms;
    logic             out_valid;
    logic             out_stall;
    logic             evaluated;
    logic             door_event;
    logic             door_status;
    logic             key_event;
    logic             key_id;
    logic             key_status;
    logic [HeldW-1:0] held_ms;

    // predictor copy of the block state and its window register
    logic [MsW-1:0]   window_ms;
    logic [MsW-1:0]   settle_ms;
    logic [KeysW-1:0] latch_keys;
    logic [1:0]       last_keys;
    logic             last_door;
    logic [HeldW-1:0] press_ms;

    // results still owed by the block, oldest first
    kdeg_result_t     due_results [$];
    kdeg_result_t     head_result;
    logic             last_evaluated;
    logic             steady_run;

    int unsigned      errors;
    int unsigned      n_ticks;
    int unsigned      n_checked;
    int unsigned      n_evals;
    int unsigned      n_key_events;
    int unsigned      n_door_events;
    int unsigned      n_saturated;
    int unsigned      n_window_writes;

    key_debounce_event_gen_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .door_pin    (door_pin),
        .stop_pin    (stop_pin),
        .onoff_pin   (onoff_pin),
        .elapsed_ms  (elapsed_ms),
        .powered     (powered),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .debounce_ms (debounce_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .evaluated   (evaluated),
        .door_event  (door_event),
        .door_status (door_status),
        .key_event   (key_event),
        .key_id      (key_id),
        .key_status  (key_status),
        .held_ms     (held_ms)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one debounce step: advances the predictor state by one tick and returns the result
    function automatic kdeg_result_t debounce_step(input kdeg_tick_t t);
        kdeg_result_t     r;
        logic [KeysW-1:0] sample;
        logic [HeldW:0]   sum;
        logic [1:0]       keys;
        logic             fire;
        logic             id;
        logic             status;
        r      = '0;
        fire   = 1'b0;
        id     = KeyIdStop;
        status = StatusSet;
        // pins are active low, latch bits are active high
        sample = {~t.door_pin, ~t.stop_pin, ~t.onoff_pin};
        // press timer runs every tick and saturates
        sum      = {1'b0, press_ms} + {{(HeldW + 1 - MsW){1'b0}}, t.elapsed_ms};
        press_ms = sum[HeldW] ? HeldMax : sum[HeldW-1:0];
        if (settle_ms != 0)
        begin
            if (latch_keys != sample)
            begin
                // pattern moved: relatch and restart the window
                latch_keys = sample;
                settle_ms  = window_ms;
                if (sample != 0)
                    press_ms = '0;
            end
            else
                settle_ms = (settle_ms > t.elapsed_ms) ? settle_ms - t.elapsed_ms : '0;
        end
        if (settle_ms == 0)
        begin
            r.evaluated = 1'b1;
            if (latch_keys[DoorIdx] != last_door)
            begin
                r.door_event  = 1'b1;
                r.door_status = latch_keys[DoorIdx];
                last_door     = latch_keys[DoorIdx];
            end
            r.held_ms = press_ms;
            settle_ms = window_ms;
            keys      = latch_keys[StopIdx:OnoffIdx];
            if (keys == KeysNone)
            begin
                // only an on/off release counts
                if (last_keys == KeysOnoff)
                begin
                    fire   = 1'b1;
                    id     = KeyIdOnoff;
                    status = StatusRelease;
                end
            end
            else if (last_keys == KeysNone)
            begin
                // single-key press from idle
                if (keys == KeysStop)
                begin
                    fire = 1'b1;
                    id   = KeyIdStop;
                end
                else if (keys == KeysOnoff)
                begin
                    fire = 1'b1;
                    id   = KeyIdOnoff;
                end
            end
            last_keys = keys;
            // powered: only on/off key events pass
            if (fire && (!t.powered || id == KeyIdOnoff))
            begin
                r.key_event  = 1'b1;
                r.key_id     = id;
                r.key_status = status;
            end
        end
        return r;
    endfunction

    // idle length between transactions: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // drive one tick transaction from a falling edge, wait for acceptance, record what is owed,
    // then idle for a random gap; returns at a falling edge with in_valid still high if no gap
    task automatic send_tick(input kdeg_tick_t t, input logic typed, input kdeg_result_t want);
        kdeg_result_t r;
        int unsigned  gap;
        in_valid   = 1'b1;
        door_pin   = t.door_pin;
        stop_pin   = t.stop_pin;
        onoff_pin  = t.onoff_pin;
        elapsed_ms = t.elapsed_ms;
        powered    = t.powered;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        r              = debounce_step(t);
        last_evaluated = r.evaluated;
        n_ticks++;
        if (r.evaluated)
            n_evals++;
        if (r.key_event)
            n_key_events++;
        if (r.door_event)
            n_door_events++;
        if (r.evaluated && r.held_ms == HeldMax)
            n_saturated++;
        due_results.push_back(typed ? want : r);
        @(negedge clk);
        gap = steady_run ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // window writes happen only with the tick channel idle and nothing owed
    task automatic write_window(input logic [MsW-1:0] value);
        in_valid = 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        cfg_valid   = 1'b1;
        debounce_ms = value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        window_ms = value;
        n_window_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one random stretch: mostly a key pattern that bounces and then settles, else pure noise
    task automatic run_sequence();
        kdeg_tick_t  t;
        int unsigned kind;
        int unsigned pick;
        int unsigned n;
        logic        door;
        logic        stop;
        logic        onoff;
        steady_run = ($urandom_range(0, 7) == 0);
        kind       = $urandom_range(0, 9);
        if (kind < 2)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                t = kdeg_tick_t'($urandom);
                send_tick(t, 1'b0, '0);
            end
        end
        else
        begin
            // target pattern, single keys favored
            door = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            stop  = !(pick >= 2 && pick <= 4 || pick >= 8);
            onoff = !(pick >= 5);
            // contact bounce before the pins settle
            n = $urandom_range(0, 3);
            repeat (n)
            begin
                t            = kdeg_tick_t'($urandom);
                t.elapsed_ms = MsW'($urandom_range(0, 8));
                send_tick(t, 1'b0, '0);
            end
            // settled pins until the latch is evaluated, at most 12 ticks
            n = 0;
            do
            begin
                t.door_pin   = door;
                t.stop_pin   = stop;
                t.onoff_pin  = onoff;
                t.elapsed_ms = ($urandom_range(0, 3) != 0) ? MsW'($urandom_range(0, 255))
                                                           : MsW'($urandom_range(0, 3));
                t.powered    = ($urandom_range(0, 2) == 0);
                send_tick(t, 1'b0, '0);
                n++;
            end
            while (!last_evaluated && n < 12);
        end
    endtask

    // results: compare each accepted transaction with the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: result with no expectation, evaluated %0d held_ms %0d",
                         $time, evaluated, held_ms);
                errors++;
            end
            else
            begin
                head_result = due_results.pop_front();
                check_field("evaluated",   head_result.evaluated,   evaluated);
                check_field("door_event",  head_result.door_event,  door_event);
                check_field("door_status", head_result.door_status, door_status);
                check_field("key_event",   head_result.key_event,   key_event);
                check_field("key_id",      head_result.key_id,      key_id);
                check_field("key_status",  head_result.key_status,  key_status);
                check_field("held_ms",     head_result.held_ms,     held_ms);
                n_checked++;
            end
        end
    end

    // result side back-pressure: short stalls, a few long ones, and stall-free stretches
    initial
    begin
        int unsigned n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
            begin
                out_stall = 1'b0;
                repeat ($urandom_range(40, 120)) @(negedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall = 1'b1;
                n = 1 + idle_len();
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // watchdog: any transaction on any channel restarts the count
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles, %0d results still owed",
                 $time, WatchLimit, due_results.size());
        $display("key_debounce_event_gen_top: mismatch");
        $finish;
    end

    initial
    begin
        logic [MsW-1:0] phase_window;
        kdeg_tick_t     t;
        int unsigned    phase_end;
        // every input known from time zero
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        door_pin    = 1'b1;
        stop_pin    = 1'b1;
        onoff_pin   = 1'b1;
        elapsed_ms  = '0;
        powered     = 1'b0;
        cfg_valid   = 1'b0;
        debounce_ms = '0;
        errors          = 0;
        n_ticks         = 0;
        n_checked       = 0;
        n_evals         = 0;
        n_key_events    = 0;
        n_door_events   = 0;
        n_saturated     = 0;
        n_window_writes = 0;
        last_evaluated  = 1'b0;
        steady_run      = 1'b0;
        // predictor state after reset
        window_ms  = DebounceRst;
        settle_ms  = '0;
        latch_keys = LatchRst;
        last_keys  = PrevKeysRst;
        last_door  = PrevDoorRst;
        press_ms   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at the reset window
        foreach (DirRows[i])
            send_tick(DirRows[i].tick, DirRows[i].typed, DirRows[i].want);

        // random phases: widest, narrowest and zero window, then random ones and once the default
        for (int unsigned phase = 0; phase < NumPhases; phase++)
        begin
            unique case (phase)
                0:       phase_window = 8'd255;
                1:       phase_window = 8'd1;
                2:       phase_window = 8'd0;
                5:       phase_window = DebounceRst;
                default: phase_window = MsW'($urandom_range(2, 254));
            endcase
            // sender holds off here until every owed result is in
            write_window(phase_window);
            phase_end = n_ticks + PhaseTicks;
            if (phase == 0)
            begin
                // long steady hold with large steps pushes the press timer to its ceiling
                steady_run = 1'b0;
                repeat (HoldTicks)
                begin
                    t.door_pin   = 1'b0;
                    t.stop_pin   = 1'b1;
                    t.onoff_pin  = 1'b0;
                    t.elapsed_ms = 8'd255;
                    t.powered    = 1'($urandom_range(0, 1));
                    send_tick(t, 1'b0, '0);
                end
            end
            while (n_ticks < phase_end)
                run_sequence();
        end

        // drain, then wait on to catch stray results
        in_valid = 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);

        $display("ran %0d ticks over %0d window settings, %0d results checked, %0d evaluations",
                 n_ticks, n_window_writes, n_checked, n_evals);
        $display("saw %0d key events, %0d door events, %0d saturated press times",
                 n_key_events, n_door_events, n_saturated);
        if (errors == 0)
            $display("key_debounce_event_gen_top: match");
        else
            $display("key_debounce_event_gen_top: mismatch");
        $finish;
    end

endmodule

>>> key_debounce_event_gen_top.f
sv/kdeg_pkg.sv
sv/kdeg_step.sv
sv/key_debounce_event_gen_top.sv
bench/key_debounce_event_gen_top_test.sv
